[hw/rtl/tceu_pkg.sv]
// ----------------------------------------------------------------------------
// tceu_pkg: shared types and constants of the tracker channel effect unit.
// Holds the beat layouts, the effect command codes, the channel mode flags,
// the note period table and the small helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tceu_pkg;

  // Period and volume bounds.
  localparam logic [11:0] PERIOD_MAX = 12'd856;
  localparam logic [11:0] PERIOD_MIN = 12'd113;
  localparam logic [6:0]  VOL_MAX    = 7'd64;

  // Number of periods in the built-in note table, and the index width.
  localparam int KNOWN_NOTES = 36;
  localparam int NOTE_IDX_W  = $clog2(KNOWN_NOTES);

  // Main effect commands.
  localparam logic [3:0] EFF_ARPEGGIO   = 4'h0;
  localparam logic [3:0] EFF_SLIDE_UP   = 4'h1;
  localparam logic [3:0] EFF_SLIDE_DOWN = 4'h2;
  localparam logic [3:0] EFF_TONE_PORTA = 4'h3;
  localparam logic [3:0] EFF_VIBRATO    = 4'h4;
  localparam logic [3:0] EFF_PORTA_VOL  = 4'h5;
  localparam logic [3:0] EFF_VIB_VOL    = 4'h6;
  localparam logic [3:0] EFF_TREMOLO    = 4'h7;
  localparam logic [3:0] EFF_PANNING    = 4'h8;
  localparam logic [3:0] EFF_OFFSET     = 4'h9;
  localparam logic [3:0] EFF_VOL_SLIDE  = 4'hA;
  localparam logic [3:0] EFF_JUMP       = 4'hB;
  localparam logic [3:0] EFF_SET_VOL    = 4'hC;
  localparam logic [3:0] EFF_BREAK      = 4'hD;
  localparam logic [3:0] EFF_EXTENDED   = 4'hE;
  localparam logic [3:0] EFF_SPEED      = 4'hF;

  // Extended (0xE) sub-commands.
  localparam logic [3:0] EXT_FINE_UP       = 4'h1;
  localparam logic [3:0] EXT_FINE_DOWN     = 4'h2;
  localparam logic [3:0] EXT_FINETUNE      = 4'h5;
  localparam logic [3:0] EXT_RETRIGGER     = 4'h9;
  localparam logic [3:0] EXT_FINE_VOL_UP   = 4'hA;
  localparam logic [3:0] EXT_FINE_VOL_DOWN = 4'hB;

  // Effect phase: idle, starts on the next tick, running.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ARMED = 2'd1,
    PH_RUN   = 2'd2
  } phase_t;

  // Channel mode flags.
  typedef struct packed {
    logic fine;
    logic targ;
    logic port;
    logic arp;
    logic stop;
  } mode_flags_t;

  // Input beat layout, last field in the lowest bits.
  typedef struct packed {
    logic [5:0]        pad;
    logic              row_repeat;
    logic              sample_present;
    logic signed [3:0] sample_finetune;
    logic [6:0]        sample_volume;
    logic [7:0]        effect_data;
    logic [3:0]        effect_code;
    logic [4:0]        sample_number;
    logic [11:0]       note_period;
    logic [3:0]        song_speed;
    logic [3:0]        tick;
  } in_item_t;

  // Output beat layout, last field in the lowest bits.
  typedef struct packed {
    logic [6:0]        pad;
    logic [15:0]       position;
    logic              load_position;
    logic              active;
    logic signed [3:0] out_finetune;
    logic [6:0]        out_volume;
    logic [11:0]       out_period;
  } out_item_t;

  // Note period table, three octaves from C-1 down to B-3.
  function automatic logic [11:0] note_period_at(input logic [NOTE_IDX_W-1:0] idx);
    logic [11:0] p;
    case (idx)
      6'd0:  p = 12'd856;  6'd1:  p = 12'd808;  6'd2:  p = 12'd762;
      6'd3:  p = 12'd720;  6'd4:  p = 12'd678;  6'd5:  p = 12'd640;
      6'd6:  p = 12'd604;  6'd7:  p = 12'd570;  6'd8:  p = 12'd538;
      6'd9:  p = 12'd508;  6'd10: p = 12'd480;  6'd11: p = 12'd453;
      6'd12: p = 12'd428;  6'd13: p = 12'd404;  6'd14: p = 12'd381;
      6'd15: p = 12'd360;  6'd16: p = 12'd339;  6'd17: p = 12'd320;
      6'd18: p = 12'd302;  6'd19: p = 12'd285;  6'd20: p = 12'd269;
      6'd21: p = 12'd254;  6'd22: p = 12'd240;  6'd23: p = 12'd226;
      6'd24: p = 12'd214;  6'd25: p = 12'd202;  6'd26: p = 12'd190;
      6'd27: p = 12'd180;  6'd28: p = 12'd170;  6'd29: p = 12'd160;
      6'd30: p = 12'd151;  6'd31: p = 12'd143;  6'd32: p = 12'd135;
      6'd33: p = 12'd127;  6'd34: p = 12'd120;
      default: p = 12'd113;
    endcase
    return p;
  endfunction

  // Volume slide step from the parameter byte: up nibble wins over down nibble.
  function automatic logic signed [4:0] vol_slide_amount(input logic [7:0] d);
    logic signed [4:0] s;
    if (d == 8'd0) begin
      s = 5'sd0;
    end else if (d[7:4] != 4'd0) begin
      s = $signed({1'b0, d[7:4]});
    end else begin
      s = 5'sd0 - $signed({1'b0, d[3:0]});
    end
    return s;
  endfunction

  // Tick number modulo three, for the arpeggio step.
  function automatic logic [1:0] tick_mod3(input logic [3:0] t);
    logic [1:0] r;
    case (t)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
      default:                              r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tracker_channel_effect_unit_top.sv]
// ----------------------------------------------------------------------------
// tracker_channel_effect_unit_top: per-tick effect processor of one channel.
// Tick 0 triggers the row's note, decodes the effect and applies fine slides,
// later ticks run the effect, and each tick reports period, volume, finetune.
//
//   Channel | Dir | Beat content                              | Width
//   --------+-----+-------------------------------------------+------
//   s_*     | in  | one tick of the channel with its note word | 56
//   m_*     | out | period, volume, finetune, position reload  | 48
//
// Each beat is registered, processed by combinational logic that also updates
// the channel state, and lands in the output register; one beat per cycle
// sustained while the output is not stalled.
// rst clears the channel state (stopped, effects off) and both valid flags.
// A stalled output holds its beat; the input register still takes one more.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tracker_channel_effect_unit_top #(
  parameter int NOTE_TABLE_DEPTH = 36
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // tdata: tick[3:0], song_speed[7:4], note_period[19:8], sample_number[24:20],
  // effect_code[28:25], effect_data[36:29], sample_volume[43:37],
  // sample_finetune[47:44], sample_present[48], row_repeat[49], zero[55:50]
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,
  // tdata: out_period[11:0], out_volume[18:12], out_finetune[22:19],
  // active[23], load_position[24], position[40:25], zero[47:41]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata
);
  import tceu_pkg::*;

  localparam int TABLE_LEN = (NOTE_TABLE_DEPTH < KNOWN_NOTES) ? NOTE_TABLE_DEPTH : KNOWN_NOTES;
  localparam logic [NOTE_IDX_W:0] LAST_IDX = (NOTE_IDX_W + 1)'(TABLE_LEN - 1);

  // Handshake and stage registers.
  logic      in_valid;
  in_item_t  item;
  out_item_t res;
  out_item_t res_next;
  logic      advance;

  // Channel state.
  logic [11:0]       period_now,  period_now_next;
  logic [11:0]       period_before;
  logic [11:0]       porta_target, porta_target_next;
  logic [6:0]        volume_now,  volume_now_next;
  logic signed [4:0] volume_step, volume_step_next;
  logic signed [8:0] slide_step,  slide_step_next;
  logic [7:0]        porta_speed, porta_speed_next;
  logic [11:0]       arp_periods [3];
  logic [11:0]       arp0_next, arp1_next, arp2_next;
  logic              arp_write;
  phase_t            effect_phase, effect_phase_next;
  mode_flags_t       mode_flags,  mode_flags_next;
  logic [3:0]        finetune_now, finetune_now_next;
  logic [3:0]        retrigger_tick, retrigger_tick_next;
  logic              current_sample_ok, current_sample_ok_next;
  logic [3:0]        current_sample_finetune, current_sample_finetune_next;

  // Arpeggio lookup.
  logic                  row_start;
  logic                  trigger;
  logic [11:0]           target_after_note;
  logic                  arp_found;
  logic [NOTE_IDX_W-1:0] arp_base;
  logic [NOTE_IDX_W:0]   arp_hi_idx, arp_lo_idx;
  logic [11:0]           arp_hi_period, arp_lo_period;

  // Effect arithmetic.
  logic signed [13:0] slide_sum;
  logic signed [12:0] porta_diff;
  logic [12:0]        porta_dist;
  logic [12:0]        porta_up;
  logic signed [13:0] porta_down;
  logic signed [7:0]  vol_sum;
  logic               load_v;
  logic [15:0]        pos_v;

  // Beat flow: the stage moves when the output register is free or drained.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= in_item_t'(s_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = res;

  // Note trigger and the period the arpeggio is built on.
  assign row_start = (item.tick == 4'd0);
  assign trigger   = row_start && !item.row_repeat &&
                     (item.note_period != 12'd0 || item.sample_number != 5'd0);
  assign target_after_note = (trigger && item.note_period != 12'd0) ?
                             item.note_period : porta_target;

  // Table search: the lowest matching entry wins.
  always_comb begin
    arp_found = 1'b0;
    arp_base  = '0;
    for (int i = TABLE_LEN - 1; i >= 0; i--) begin
      if (note_period_at(NOTE_IDX_W'(i)) == target_after_note) begin
        arp_found = 1'b1;
        arp_base  = NOTE_IDX_W'(i);
      end
    end
  end

  // Arpeggio steps, held at the last table entry.
  always_comb begin
    arp_hi_idx = {1'b0, arp_base} + {{(NOTE_IDX_W - 3){1'b0}}, item.effect_data[7:4]};
    arp_lo_idx = {1'b0, arp_base} + {{(NOTE_IDX_W - 3){1'b0}}, item.effect_data[3:0]};
    if (arp_hi_idx > LAST_IDX) arp_hi_idx = LAST_IDX;
    if (arp_lo_idx > LAST_IDX) arp_lo_idx = LAST_IDX;
    arp_hi_period = note_period_at(arp_hi_idx[NOTE_IDX_W-1:0]);
    arp_lo_period = note_period_at(arp_lo_idx[NOTE_IDX_W-1:0]);
  end

  // Per-tick channel update: row start, retrigger, running effect, row end.
  always_comb begin
    period_now_next              = period_now;
    porta_target_next            = porta_target;
    volume_now_next              = volume_now;
    volume_step_next             = volume_step;
    slide_step_next              = slide_step;
    porta_speed_next             = porta_speed;
    effect_phase_next            = effect_phase;
    mode_flags_next              = mode_flags;
    finetune_now_next            = finetune_now;
    retrigger_tick_next          = retrigger_tick;
    current_sample_ok_next       = current_sample_ok;
    current_sample_finetune_next = current_sample_finetune;
    arp_write  = 1'b0;
    arp0_next  = target_after_note;
    arp1_next  = arp_hi_period;
    arp2_next  = arp_lo_period;
    load_v     = 1'b0;
    pos_v      = '0;
    slide_sum  = '0;
    porta_diff = '0;
    porta_dist = '0;
    porta_up   = '0;
    porta_down = '0;
    vol_sum    = '0;

    if (row_start) begin
      // Note and sample trigger.
      if (trigger) begin
        if (item.sample_number != 5'd0) begin
          current_sample_ok_next       = item.sample_present;
          current_sample_finetune_next = item.sample_finetune;
          volume_now_next = (item.sample_volume > VOL_MAX) ? VOL_MAX : item.sample_volume;
        end
        if (item.note_period != 12'd0) begin
          period_now_next      = item.note_period;
          porta_target_next    = item.note_period;
          mode_flags_next.stop = 1'b0;
          load_v               = 1'b1;
        end
        finetune_now_next = current_sample_finetune_next;
      end
      if (period_now_next == 12'd0 || !current_sample_ok_next) begin
        mode_flags_next.stop = 1'b1;
      end
      volume_step_next  = 5'sd0;
      effect_phase_next = PH_IDLE;

      // Effect decode.
      unique case (item.effect_code) inside
        EFF_ARPEGGIO: begin
          if (item.effect_data != 8'd0) begin
            period_now_next      = porta_target_next;
            mode_flags_next.arp  = arp_found;
            mode_flags_next.port = 1'b0;
            if (arp_found) begin
              arp_write         = 1'b1;
              effect_phase_next = PH_ARMED;
            end
          end
        end
        EFF_SLIDE_UP, EFF_SLIDE_DOWN: begin
          mode_flags_next.targ = 1'b0;
          mode_flags_next.arp  = 1'b0;
          mode_flags_next.port = 1'b1;
          mode_flags_next.fine = 1'b0;
          slide_step_next = (item.effect_code == EFF_SLIDE_UP) ?
                            9'sd0 - $signed({1'b0, item.effect_data}) :
                            $signed({1'b0, item.effect_data});
          volume_step_next  = 5'sd0;
          effect_phase_next = PH_ARMED;
        end
        EFF_TONE_PORTA, EFF_PORTA_VOL: begin
          if (item.effect_code == EFF_TONE_PORTA) begin
            if (item.effect_data != 8'd0) porta_speed_next = item.effect_data;
            volume_step_next    = 5'sd0;
            mode_flags_next.arp = 1'b0;
          end else begin
            volume_step_next = vol_slide_amount(item.effect_data);
          end
          period_now_next      = period_before;
          mode_flags_next.targ = 1'b1;
          mode_flags_next.port = 1'b1;
          mode_flags_next.fine = 1'b0;
          mode_flags_next.stop = 1'b0;
          effect_phase_next    = PH_ARMED;
        end
        EFF_OFFSET: begin
          load_v = 1'b1;
          pos_v  = {item.effect_data, 8'h00};
        end
        EFF_VOL_SLIDE: begin
          volume_step_next     = vol_slide_amount(item.effect_data);
          mode_flags_next.fine = 1'b0;
          effect_phase_next    = PH_ARMED;
        end
        EFF_SET_VOL: begin
          volume_step_next = 5'sd0;
          volume_now_next  = (item.effect_data > 8'(VOL_MAX)) ? VOL_MAX :
                             item.effect_data[6:0];
        end
        EFF_EXTENDED: begin
          unique case (item.effect_data[7:4]) inside
            EXT_FINE_UP, EXT_FINE_DOWN: begin
              mode_flags_next.targ = 1'b0;
              mode_flags_next.arp  = 1'b0;
              mode_flags_next.port = 1'b1;
              mode_flags_next.fine = 1'b1;
              slide_step_next = (item.effect_data[7:4] == EXT_FINE_UP) ?
                                9'sd0 - $signed({5'b0, item.effect_data[3:0]}) :
                                $signed({5'b0, item.effect_data[3:0]});
              volume_step_next  = 5'sd0;
              effect_phase_next = PH_RUN;
            end
            EXT_FINETUNE: begin
              finetune_now_next = item.effect_data[3:0];
            end
            EXT_RETRIGGER: begin
              retrigger_tick_next = item.effect_data[3:0];
            end
            EXT_FINE_VOL_UP, EXT_FINE_VOL_DOWN: begin
              mode_flags_next.targ = 1'b0;
              mode_flags_next.arp  = 1'b0;
              mode_flags_next.port = 1'b0;
              mode_flags_next.fine = 1'b1;
              volume_step_next = (item.effect_data[7:4] == EXT_FINE_VOL_UP) ?
                                 $signed({1'b0, item.effect_data[3:0]}) :
                                 5'sd0 - $signed({1'b0, item.effect_data[3:0]});
              effect_phase_next = PH_RUN;
            end
            default: begin
            end
          endcase
        end
        EFF_JUMP, EFF_BREAK, EFF_SPEED: begin
          mode_flags_next.port = 1'b0;
        end
        default: begin
          // Vibrato, vibrato-volume, tremolo and panning are not handled here.
        end
      endcase
    end

    // Retrigger restarts the sample from the beginning.
    if (retrigger_tick_next != 4'd0 && item.tick == retrigger_tick_next - 4'd1) begin
      load_v               = 1'b1;
      pos_v                = '0;
      mode_flags_next.stop = 1'b0;
    end

    // Running effect.
    if (effect_phase_next == PH_RUN) begin
      if (mode_flags_next.arp) begin
        case (tick_mod3(item.tick))
          2'd0:    period_now_next = arp_periods[0];
          2'd1:    period_now_next = arp_periods[1];
          default: period_now_next = arp_periods[2];
        endcase
      end else if (mode_flags_next.port) begin
        if (mode_flags_next.targ) begin
          porta_diff = $signed({1'b0, porta_target_next}) - $signed({1'b0, period_now_next});
          porta_dist = porta_diff[12] ? 13'(-porta_diff) : 13'(porta_diff);
          porta_up   = {1'b0, period_now_next} + {5'b0, porta_speed_next};
          porta_down = $signed({2'b00, period_now_next}) - $signed({6'b0, porta_speed_next});
          if (porta_dist < {5'b0, porta_speed_next}) begin
            period_now_next      = porta_target_next;
            mode_flags_next.port = 1'b0;
          end else if (porta_target_next > period_now_next) begin
            period_now_next = (porta_up > {1'b0, PERIOD_MAX}) ? PERIOD_MAX : porta_up[11:0];
          end else begin
            period_now_next = (porta_down < $signed({2'b00, PERIOD_MIN})) ?
                              PERIOD_MIN : porta_down[11:0];
          end
        end else begin
          slide_sum = $signed({2'b00, period_now_next}) +
                      $signed({{5{slide_step_next[8]}}, slide_step_next});
          if (slide_sum > $signed({2'b00, PERIOD_MAX})) begin
            period_now_next = PERIOD_MAX;
          end else if (slide_sum < $signed({2'b00, PERIOD_MIN})) begin
            period_now_next = PERIOD_MIN;
          end else begin
            period_now_next = slide_sum[11:0];
          end
        end
      end
      vol_sum = $signed({1'b0, volume_now_next}) +
                $signed({{3{volume_step_next[4]}}, volume_step_next});
      if (vol_sum < 8'sd0) begin
        volume_now_next = 7'd0;
      end else if (vol_sum > $signed({1'b0, VOL_MAX})) begin
        volume_now_next = VOL_MAX;
      end else begin
        volume_now_next = vol_sum[6:0];
      end
      if (mode_flags_next.fine) effect_phase_next = PH_IDLE;
    end else if (effect_phase_next == PH_ARMED) begin
      effect_phase_next = PH_RUN;
    end

    // Result beat, taken before the row end clears the running effect.
    res_next.pad           = '0;
    res_next.position      = pos_v;
    res_next.load_position = load_v;
    res_next.active        = !mode_flags_next.stop;
    res_next.out_finetune  = finetune_now_next;
    res_next.out_volume    = volume_now_next;
    res_next.out_period    = period_now_next;

    // Row end stops slides, arpeggio and retrigger.
    if (item.song_speed != 4'd0 && item.tick == item.song_speed - 4'd1) begin
      mode_flags_next.port = 1'b0;
      mode_flags_next.arp  = 1'b0;
      effect_phase_next    = PH_IDLE;
      retrigger_tick_next  = 4'd0;
    end
  end

  // Channel state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      period_now              <= '0;
      period_before           <= '0;
      porta_target            <= '0;
      volume_now              <= '0;
      volume_step             <= '0;
      slide_step              <= '0;
      porta_speed             <= '0;
      effect_phase            <= PH_IDLE;
      mode_flags              <= '{fine: 1'b0, targ: 1'b0, port: 1'b0, arp: 1'b0, stop: 1'b1};
      finetune_now            <= '0;
      retrigger_tick          <= '0;
      current_sample_ok       <= 1'b0;
      current_sample_finetune <= '0;
    end else if (advance) begin
      period_now              <= period_now_next;
      period_before           <= period_now_next;
      porta_target            <= porta_target_next;
      volume_now              <= volume_now_next;
      volume_step             <= volume_step_next;
      slide_step              <= slide_step_next;
      porta_speed             <= porta_speed_next;
      effect_phase            <= effect_phase_next;
      mode_flags              <= mode_flags_next;
      finetune_now            <= finetune_now_next;
      retrigger_tick          <= retrigger_tick_next;
      current_sample_ok       <= current_sample_ok_next;
      current_sample_finetune <= current_sample_finetune_next;
    end
  end

  // Arpeggio periods, written when an arpeggio starts.
  always_ff @(posedge clk) begin
    if (advance && arp_write) begin
      arp_periods[0] <= arp0_next;
      arp_periods[1] <= arp1_next;
      arp_periods[2] <= arp2_next;
    end
  end

endmodule

`default_nettype wire
